// ===== hdl/assert_macros.svh =====
// Assertion macros used by the flood fill RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/tff_pkg.sv =====
// Shared constants, types and helper functions of the tolerance flood fill.
`default_nettype none
package tff_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = $clog2(MAX_WIDTH + 1);
    localparam int PROD_W     = 2 * DIM_W;
    localparam int PIX_W      = 32;
    localparam int TOL_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd6;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] ST_FILLED    = 2'd0;
    localparam logic [1:0] ST_SEED_OUT  = 2'd1;
    localparam logic [1:0] ST_SEED_SAME = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [X_W-1:0]   seed_x;
        logic [Y_W-1:0]   seed_y;
        logic [PIX_W-1:0] fill_color;
        logic [TOL_W-1:0] tol;
        logic             mask_mode;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] index;
        logic              in_range;
        logic [PIX_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       run_status;
        logic [PIX_W-1:0] read_value;
        logic             in_region;
        logic [X_W-1:0]   box_x;
        logic [Y_W-1:0]   box_y;
        logic [DIM_W-1:0] box_w;
        logic [DIM_W-1:0] box_h;
    } res_t;

    // Largest absolute byte difference over the four channels.
    function automatic logic [7:0] color_dist(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        logic [7:0] worst;
        logic [7:0] ca;
        logic [7:0] cb;
        logic [7:0] d;
        worst = '0;
        for (int i = 0; i < 4; i++) begin
            ca = a[8*i +: 8];
            cb = b[8*i +: 8];
            d  = (ca > cb) ? (ca - cb) : (cb - ca);
            if (d > worst) begin
                worst = d;
            end
        end
        return worst;
    endfunction

    function automatic logic [ADDR_W-1:0] raster(input logic [X_W-1:0]   x,
                                                 input logic [Y_W-1:0]   y,
                                                 input logic [DIM_W-1:0] w);
        logic [PROD_W-1:0] p;
        p = PROD_W'(y) * PROD_W'(w) + PROD_W'(x);
        return p[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/tolerance_flood_fill_core.sv =====
// Top level of the tolerance flood fill: RGBA image store with a 4-connected region fill.
// Requests enter by push/full and results leave by empty/pop; one word per handshake.
// Write words store a pixel and return nothing; read words return the pixel, its region
// mark and the last run's status and rectangle; run words fill from the seed and return
// the status and the rectangle of the region.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must do so only while
// the block is idle; the block does not enforce it. A write is stored when popped, and a
// read holds the sequencer in S_RD_OUT until its result is pushed. A run first clears the
// region map, one entry per cycle, then reads the seed in S_SEED_RD and S_SEED_CHK unless
// it lies outside the image, pops each region pixel in S_POP and S_POP_WAIT and tries its
// four neighbor directions in S_NB_SEL, checking each in-image one in S_NB_CHK, as the
// image and map memories give one read per cycle. Runs are carried out one at a time.
// After reset full stays high while the region map is cleared in the same way.
// Two command words and two result words are buffered; when the receiver does not pop,
// the sequencer waits with its result and full rises once the command queue is full.
`default_nettype none
`include "assert_macros.svh"
module tolerance_flood_fill_core
    import tff_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [1:0]            req_type,
    input  wire logic [ADDR_W-1:0]     pixel_index,
    input  wire logic [PIX_W-1:0]      pixel_value,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [1:0]                 run_status,
    output logic [PIX_W-1:0]           read_value,
    output logic                       in_region,
    output logic [X_W-1:0]             box_x,
    output logic [Y_W-1:0]             box_y,
    output logic [DIM_W-1:0]           box_w,
    output logic [DIM_W-1:0]           box_h
);

    cfg_t cfg;
    cmd_t cmd;
    res_t res;
    res_t res_out;
    logic cmd_valid;
    logic cmd_pop;
    logic init_busy;
    logic res_full;
    logic res_push;

    tff_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .pixel_index (pixel_index),
        .pixel_value (pixel_value),
        .init_busy   (init_busy),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd),
        .cfg         (cfg)
    );

    tff_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .init_busy (init_busy),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    tff_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .res_out  (res_out)
    );

    assign run_status = res_out.run_status;
    assign read_value = res_out.read_value;
    assign in_region  = res_out.in_region;
    assign box_x      = res_out.box_x;
    assign box_y      = res_out.box_y;
    assign box_w      = res_out.box_w;
    assign box_h      = res_out.box_h;

    `CHK_IMPLY(a_res_room, clk, rst_n, res_push, !res_full)
    `CHK_IMPLY(a_pop_valid, clk, rst_n, cmd_pop, cmd_valid)
    `CHK_IMPLY(a_init_no_cmd, clk, rst_n, init_busy, !cmd_pop && full)
    `CHK_NEXT(a_res_visible, clk, rst_n, res_push, !empty)

endmodule
`default_nettype wire

// ===== hdl/tff_front.sv =====
// Front end: configuration registers, request classification and command queue.
`default_nettype none
module tff_front
    import tff_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [1:0]            req_type,
    input  wire logic [ADDR_W-1:0]     pixel_index,
    input  wire logic [PIX_W-1:0]      pixel_value,
    input  wire logic                  init_busy,
    output logic                       cmd_valid,
    input  wire logic                  cmd_pop,
    output cmd_t                       cmd,
    output cfg_t                       cfg
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [X_W-1:0]   seed_x_reg;
    logic [Y_W-1:0]   seed_y_reg;
    logic [PIX_W-1:0] color_reg;
    logic [TOL_W-1:0] tol_reg;
    logic             mode_reg;

    cmd_t       q_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    logic [PROD_W-1:0] cells;
    logic              in_range;
    logic              accept;
    logic              enq;
    cmd_t              new_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
            seed_x_reg <= '0;
            seed_y_reg <= '0;
            color_reg  <= '0;
            tol_reg    <= '0;
            mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                REG_SEED_X: seed_x_reg <= cfg_data[X_W-1:0];
                REG_SEED_Y: seed_y_reg <= cfg_data[Y_W-1:0];
                REG_COLOR:  color_reg  <= cfg_data[PIX_W-1:0];
                REG_TOL:    tol_reg    <= cfg_data[TOL_W-1:0];
                REG_MODE:   mode_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Image sizes saturate into the supported range.
    always_comb
    begin
        cfg.width      = width_reg;
        cfg.height     = height_reg;
        if (width_reg == '0)
        begin
            cfg.width = DIM_W'(1);
        end
        else if (width_reg > DIM_W'(MAX_WIDTH))
        begin
            cfg.width = DIM_W'(MAX_WIDTH);
        end
        if (height_reg == '0)
        begin
            cfg.height = DIM_W'(1);
        end
        else if (height_reg > DIM_W'(MAX_HEIGHT))
        begin
            cfg.height = DIM_W'(MAX_HEIGHT);
        end
        cfg.seed_x     = seed_x_reg;
        cfg.seed_y     = seed_y_reg;
        cfg.fill_color = color_reg;
        cfg.tol        = tol_reg;
        cfg.mask_mode  = mode_reg;
    end

    assign cells    = PROD_W'(cfg.width) * PROD_W'(cfg.height);
    assign in_range = PROD_W'(pixel_index) < cells;
    assign full     = (cnt_reg == 2'd2) || init_busy;
    assign accept   = push && !full;

    // Unknown requests and writes outside the image are dropped here.
    assign enq = accept && ((req_type == OP_RUN) || (req_type == OP_READ) ||
                            ((req_type == OP_WRITE) && in_range));

    assign new_cmd.op       = req_type;
    assign new_cmd.index    = pixel_index;
    assign new_cmd.in_range = in_range;
    assign new_cmd.value    = pixel_value;

    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (enq && !cmd_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!enq && cmd_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (enq)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/tff_back.sv =====
// Back end: image, region map and pending stack with the fill sequencer.
`default_nettype none
module tff_back
    import tff_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd,
    output logic      cmd_pop,
    output logic      init_busy,
    input  wire logic res_full,
    output logic      res_push,
    output res_t      res
);

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_CLR      = 4'd2;
    localparam logic [3:0] S_SEED_RD  = 4'd3;
    localparam logic [3:0] S_SEED_CHK = 4'd4;
    localparam logic [3:0] S_POP      = 4'd5;
    localparam logic [3:0] S_POP_WAIT = 4'd6;
    localparam logic [3:0] S_NB_SEL   = 4'd7;
    localparam logic [3:0] S_NB_CHK   = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;
    localparam logic [3:0] S_RD_OUT   = 4'd10;

    localparam logic [1:0] NB_RIGHT = 2'd0;
    localparam logic [1:0] NB_LEFT  = 2'd1;
    localparam logic [1:0] NB_DOWN  = 2'd2;
    localparam logic [1:0] NB_UP    = 2'd3;

    localparam int STK_W = X_W + Y_W;

    logic [PIX_W-1:0] img_mem [CELLS];
    logic             vis_mem [CELLS];
    logic [STK_W-1:0] stk_mem [CELLS];
    logic [PIX_W-1:0] img_rd_reg;
    logic             vis_rd_reg;
    logic [STK_W-1:0] stk_rd_reg;

    logic [3:0]        state_reg,  state_next;
    logic [ADDR_W-1:0] clr_reg,    clr_next;
    logic [ADDR_W:0]   top_reg,    top_next;
    logic [1:0]        nb_reg,     nb_next;
    logic [1:0]        status_reg, status_next;
    logic [X_W-1:0]    minx_reg,   minx_next;
    logic [Y_W-1:0]    miny_reg,   miny_next;
    logic [X_W-1:0]    maxx_reg,   maxx_next;
    logic [Y_W-1:0]    maxy_reg,   maxy_next;
    logic              bvalid_reg, bvalid_next;
    logic [X_W-1:0]    px_reg,     px_next;
    logic [Y_W-1:0]    py_reg,     py_next;
    logic [X_W-1:0]    nx_reg,     nx_next;
    logic [Y_W-1:0]    ny_reg,     ny_next;
    logic [PIX_W-1:0]  seed_c_reg, seed_c_next;
    logic [ADDR_W-1:0] idx_reg,    idx_next;
    logic              inr_reg,    inr_next;

    logic              ra_use_idx;
    logic [ADDR_W-1:0] ra_idx;
    logic [X_W-1:0]    ra_x;
    logic [Y_W-1:0]    ra_y;
    logic [ADDR_W-1:0] ra;
    logic              wa_use_idx;
    logic [ADDR_W-1:0] wa_idx;
    logic [X_W-1:0]    wa_x;
    logic [Y_W-1:0]    wa_y;
    logic [ADDR_W-1:0] wa;
    logic              img_we;
    logic [PIX_W-1:0]  img_wd;
    logic              vis_we;
    logic              vis_wd;
    logic              stk_we;
    logic [STK_W-1:0]  stk_wd;
    logic [ADDR_W-1:0] stk_ra;

    logic              cand_ok;
    logic [X_W-1:0]    cand_x;
    logic [Y_W-1:0]    cand_y;
    logic              seed_out;
    logic              joins;
    res_t              box_res;

    assign ra = ra_use_idx ? ra_idx : raster(ra_x, ra_y, cfg.width);
    assign wa = wa_use_idx ? wa_idx : raster(wa_x, wa_y, cfg.width);
    assign stk_ra = top_reg[ADDR_W-1:0] - ADDR_W'(1);

    assign init_busy = (state_reg == S_INIT);
    assign seed_out  = (DIM_W'(cfg.seed_x) >= cfg.width) ||
                       (DIM_W'(cfg.seed_y) >= cfg.height);
    assign joins     = !vis_rd_reg && (color_dist(img_rd_reg, seed_c_reg) <= cfg.tol);

    always_comb
    begin
        cand_ok = 1'b0;
        cand_x  = px_reg;
        cand_y  = py_reg;
        case (nb_reg)
            NB_RIGHT:
            begin
                cand_ok = (DIM_W'(px_reg) + DIM_W'(1)) < cfg.width;
                cand_x  = px_reg + X_W'(1);
            end
            NB_LEFT:
            begin
                cand_ok = (px_reg != '0);
                cand_x  = px_reg - X_W'(1);
            end
            NB_DOWN:
            begin
                cand_ok = (DIM_W'(py_reg) + DIM_W'(1)) < cfg.height;
                cand_y  = py_reg + Y_W'(1);
            end
            NB_UP:
            begin
                cand_ok = (py_reg != '0);
                cand_y  = py_reg - Y_W'(1);
            end
            default: ;
        endcase
    end

    // Status and rectangle as they stand after the last run.
    always_comb
    begin
        box_res.run_status = status_reg;
        box_res.read_value = '0;
        box_res.in_region  = 1'b0;
        box_res.box_x      = bvalid_reg ? minx_reg : '0;
        box_res.box_y      = bvalid_reg ? miny_reg : '0;
        box_res.box_w      = bvalid_reg ?
            (DIM_W'(maxx_reg) - DIM_W'(minx_reg) + DIM_W'(1)) : '0;
        box_res.box_h      = bvalid_reg ?
            (DIM_W'(maxy_reg) - DIM_W'(miny_reg) + DIM_W'(1)) : '0;
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        top_next    = top_reg;
        nb_next     = nb_reg;
        status_next = status_reg;
        minx_next   = minx_reg;
        miny_next   = miny_reg;
        maxx_next   = maxx_reg;
        maxy_next   = maxy_reg;
        bvalid_next = bvalid_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        nx_next     = nx_reg;
        ny_next     = ny_reg;
        seed_c_next = seed_c_reg;
        idx_next    = idx_reg;
        inr_next    = inr_reg;

        ra_use_idx = 1'b0;
        ra_idx     = idx_reg;
        ra_x       = nx_reg;
        ra_y       = ny_reg;
        wa_use_idx = 1'b0;
        wa_idx     = clr_reg;
        wa_x       = nx_reg;
        wa_y       = ny_reg;
        img_we     = 1'b0;
        img_wd     = cfg.fill_color;
        vis_we     = 1'b0;
        vis_wd     = 1'b0;
        stk_we     = 1'b0;
        stk_wd     = {ny_reg, nx_reg};
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        res        = box_res;

        case (state_reg)
            S_INIT:
            begin
                vis_we     = 1'b1;
                wa_use_idx = 1'b1;
                clr_next   = clr_reg + ADDR_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ra_use_idx = 1'b1;
                ra_idx     = cmd.index;
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_WRITE:
                        begin
                            img_we     = 1'b1;
                            img_wd     = cmd.value;
                            wa_use_idx = 1'b1;
                            wa_idx     = cmd.index;
                        end
                        OP_RUN:
                        begin
                            clr_next    = '0;
                            top_next    = '0;
                            bvalid_next = 1'b0;
                            minx_next   = '0;
                            miny_next   = '0;
                            maxx_next   = '0;
                            maxy_next   = '0;
                            state_next  = S_CLR;
                        end
                        OP_READ:
                        begin
                            idx_next   = cmd.index;
                            inr_next   = cmd.in_range;
                            state_next = S_RD_OUT;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_OUT:
            begin
                ra_use_idx = 1'b1;
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (inr_reg)
                    begin
                        res.read_value = img_rd_reg;
                        res.in_region  = vis_rd_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            S_CLR:
            begin
                vis_we     = 1'b1;
                wa_use_idx = 1'b1;
                clr_next   = clr_reg + ADDR_W'(1);
                if (clr_reg == '1)
                begin
                    if (seed_out)
                    begin
                        status_next = ST_SEED_OUT;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SEED_RD;
                    end
                end
            end
            S_SEED_RD:
            begin
                ra_x       = cfg.seed_x;
                ra_y       = cfg.seed_y;
                state_next = S_SEED_CHK;
            end
            S_SEED_CHK:
            begin
                seed_c_next = img_rd_reg;
                if (!cfg.mask_mode && (img_rd_reg == cfg.fill_color))
                begin
                    status_next = ST_SEED_SAME;
                    state_next  = S_DONE;
                end
                else
                begin
                    status_next = ST_FILLED;
                    wa_x        = cfg.seed_x;
                    wa_y        = cfg.seed_y;
                    vis_we      = 1'b1;
                    vis_wd      = 1'b1;
                    img_we      = !cfg.mask_mode;
                    stk_we      = 1'b1;
                    stk_wd      = {cfg.seed_y, cfg.seed_x};
                    top_next    = top_reg + (ADDR_W+1)'(1);
                    minx_next   = cfg.seed_x;
                    miny_next   = cfg.seed_y;
                    maxx_next   = cfg.seed_x;
                    maxy_next   = cfg.seed_y;
                    bvalid_next = 1'b1;
                    state_next  = S_POP;
                end
            end
            S_POP:
            begin
                if (top_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    top_next   = top_reg - (ADDR_W+1)'(1);
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                px_next    = stk_rd_reg[X_W-1:0];
                py_next    = stk_rd_reg[STK_W-1:X_W];
                nb_next    = NB_RIGHT;
                state_next = S_NB_SEL;
            end
            S_NB_SEL:
            begin
                ra_x = cand_x;
                ra_y = cand_y;
                if (cand_ok)
                begin
                    nx_next    = cand_x;
                    ny_next    = cand_y;
                    state_next = S_NB_CHK;
                end
                else if (nb_reg == NB_UP)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    nb_next = nb_reg + 2'd1;
                end
            end
            S_NB_CHK:
            begin
                // A neighbor is marked when pushed, so each region pixel
                // enters the stack exactly once.
                if (joins)
                begin
                    vis_we   = 1'b1;
                    vis_wd   = 1'b1;
                    img_we   = !cfg.mask_mode;
                    stk_we   = 1'b1;
                    top_next = top_reg + (ADDR_W+1)'(1);
                    if (nx_reg < minx_reg)
                    begin
                        minx_next = nx_reg;
                    end
                    if (ny_reg < miny_reg)
                    begin
                        miny_next = ny_reg;
                    end
                    if (nx_reg > maxx_reg)
                    begin
                        maxx_next = nx_reg;
                    end
                    if (ny_reg > maxy_reg)
                    begin
                        maxy_next = ny_reg;
                    end
                end
                if (nb_reg == NB_UP)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    nb_next    = nb_reg + 2'd1;
                    state_next = S_NB_SEL;
                end
            end
            S_DONE:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            clr_reg    <= '0;
            top_reg    <= '0;
            nb_reg     <= NB_RIGHT;
            status_reg <= ST_FILLED;
            minx_reg   <= '0;
            miny_reg   <= '0;
            maxx_reg   <= '0;
            maxy_reg   <= '0;
            bvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            top_reg    <= top_next;
            nb_reg     <= nb_next;
            status_reg <= status_next;
            minx_reg   <= minx_next;
            miny_reg   <= miny_next;
            maxx_reg   <= maxx_next;
            maxy_reg   <= maxy_next;
            bvalid_reg <= bvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        seed_c_reg <= seed_c_next;
        idx_reg    <= idx_next;
        inr_reg    <= inr_next;
    end

    always_ff @(posedge clk)
    begin
        if (img_we)
        begin
            img_mem[wa] <= img_wd;
        end
        img_rd_reg <= img_mem[ra];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[wa] <= vis_wd;
        end
        vis_rd_reg <= vis_mem[ra];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[top_reg[ADDR_W-1:0]] <= stk_wd;
        end
        stk_rd_reg <= stk_mem[stk_ra];
    end

endmodule
`default_nettype wire

// ===== hdl/tff_outq.sv =====
// Two-entry result queue that drives the result side of the block.
`default_nettype none
module tff_outq
    import tff_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic res_push,
    input  wire res_t res_in,
    output logic      res_full,
    input  wire logic pop,
    output logic      empty,
    output res_t      res_out
);

    res_t       q_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       deq;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign deq      = pop && !empty;
    assign res_out  = q_mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (res_push && !deq)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!res_push && deq)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (res_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (deq)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_mem[wr_ptr_reg] <= res_in;
        end
    end

endmodule
`default_nettype wire
